// File: rtl/ajbs_pkg.sv
`timescale 1ns / 1ps
package ajbs_pkg;
  localparam int RingDepth = 64;
  localparam int RingAw = $clog2(RingDepth);
  localparam int PacketMs = 20;
  localparam int StatLimit = 262143;
  localparam int GrowGapMs = 1000;

  typedef enum logic [1:0] {
    FUNC_BASE = 2'd0,
    FUNC_RECORD = 2'd1,
    FUNC_ADJUST = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MIN_SIZE = 3'd0,
    REG_MAX_SIZE = 3'd1,
    REG_REDUCE_HOLD = 3'd2,
    REG_STEP_SIZE = 3'd3,
    REG_Z_FACTOR = 3'd4,
    REG_IMPROVED = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] rtp_timestamp;
    logic [31:0] arrival_ms;
    logic [9:0]  current_size;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic signed [31:0] jitter_ms;
    logic [9:0]         next_size;
    logic [1:0]         net_status;
  } result_t;
endpackage

// File: rtl/adaptive_jitter_buffer_sizer.sv
`timescale 1ns / 1ps
// sequence: set base and unused codes go to S_OUT, which raises done; record
// goes through S_REC, then S_OUT; adjust runs S_SUM, S_MEAN, S_VAR, S_SQRT, S_MUL,
// S_DECIDE, S_GROW when the estimate reaches the capacity, then S_OUT (two ring
// passes through the one-port ring memory, a 32-step square root, then a multiply and decide)
// one item at a time; busy is high until done; the receiver cannot stall
// reset: synchronous active high; the ring is cleared by a sweep over all
// RingDepth entries after reset, during which busy stays high
module adaptive_jitter_buffer_sizer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ajbs_pkg::item_t      item,
  output logic                 busy,
  output logic                 done,
  output ajbs_pkg::result_t    result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import ajbs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REC, S_SUM, S_MEAN, S_VAR, S_SQRT, S_MUL, S_DECIDE,
    S_GROW, S_OUT
  } state_t;

  state_t state;

  logic [9:0]  min_size, max_size;
  logic [31:0] reduce_hold_ms;
  logic [7:0]  step_size;
  logic [11:0] z_factor;
  logic        improved_mode;

  logic [31:0] base_timestamp, base_arrival;
  logic        base_valid;
  logic [RingAw-1:0] ring_pointer;
  status_t     status_reg;
  logic [31:0] good_since_ms, last_grow_ms;
  logic        grow_valid;

  logic [31:0] ring [RingDepth];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [RingAw-1:0] mem_addr;
  logic [31:0] mem_wdata;

  item_t       it;
  logic [RingAw:0] cnt;
  logic signed [31:0] jit;
  logic signed [31:0] maxj;
  logic signed [31:0] sum;
  logic signed [39:0] mean_q8;
  logic [63:0] sq;
  logic [63:0] var_q16;
  logic [31:0] root;
  logic [5:0]  bit_i;
  logic signed [40:0] est;
  logic [40:0] wgt;

  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_addr] <= mem_wdata;
    rd_data <= ring[mem_addr];
  end

  // saturated value of the entry just read
  logic signed [31:0] rd_s, rd_sat;
  logic signed [40:0] dv;
  logic [40:0] dabs;
  logic [63:0] trial_sq;
  logic [31:0] trial;
  logic signed [40:0] cap_q8, thr_q8;
  logic signed [31:0] thr;
  logic signed [40:0] zprod;
  logic [31:0] wq;
  logic [63:0] wprod;

  always_comb begin
    rd_s = $signed(rd_data);
    if (rd_s > $signed(32'(StatLimit))) rd_sat = 32'(StatLimit);
    else if (rd_s < -$signed(32'(StatLimit))) rd_sat = -32'(StatLimit);
    else rd_sat = rd_s;
    dv = {{1{rd_sat[31]}}, rd_sat, 8'd0} - {mean_q8[39], mean_q8};
    dabs = dv[40] ? 41'(-dv) : 41'(dv);
    trial = root | (32'd1 << bit_i[4:0]);
    trial_sq = trial * trial;
    cap_q8 = 41'($signed({1'b0, it.current_size}) * PacketMs) <<< 8;
    thr = 32'($signed({1'b0, it.current_size}) - 1) * PacketMs - 10;
    thr_q8 = 41'(thr) <<< 8;
    zprod = 41'(({32'd0, z_factor} * {32'd0, root}) >> 8);
    // excess over 20*256 split as a shift by 1024 and a reciprocal divide by 5
    wq = 32'((est - cap_q8) >>> 10);
    wprod = {32'd0, wq} * 64'h0000_0000_CCCC_CCCD;
  end

  logic [RingAw-1:0] cnt_lo;
  assign cnt_lo = cnt[RingAw-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_addr = cnt_lo;
    mem_wdata = 32'd0;
    if (state == S_CLEAR) mem_we = 1'b1;
    else if (state == S_REC) begin
      mem_we = base_valid;
      mem_addr = ring_pointer;
      mem_wdata = jit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      done <= 1'b0;
      min_size <= '0;
      max_size <= '0;
      reduce_hold_ms <= 32'd20000;
      step_size <= 8'd2;
      z_factor <= 12'd640;
      improved_mode <= 1'b0;
      base_timestamp <= '0;
      base_arrival <= '0;
      base_valid <= 1'b0;
      ring_pointer <= '0;
      status_reg <= ST_NORMAL;
      good_since_ms <= '0;
      last_grow_ms <= '0;
      grow_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_SIZE:    min_size <= cfg_data[9:0];
          REG_MAX_SIZE:    max_size <= cfg_data[9:0];
          REG_REDUCE_HOLD: reduce_hold_ms <= cfg_data;
          REG_STEP_SIZE:   step_size <= cfg_data[7:0];
          REG_Z_FACTOR:    z_factor <= cfg_data[11:0];
          REG_IMPROVED:    improved_mode <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt_lo == RingAw'(RingDepth - 1)) begin
            cnt <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            it <= item;
            jit <= (item.arrival_ms - base_arrival) - (item.rtp_timestamp - base_timestamp);
            cnt <= '0;
            unique case (func_t'(item.func))
              FUNC_BASE: begin
                base_timestamp <= item.rtp_timestamp;
                base_arrival <= item.arrival_ms;
                base_valid <= 1'b1;
                result <= '{32'sd0, item.current_size, status_reg};
                state <= S_OUT;
              end
              FUNC_RECORD: state <= S_REC;
              FUNC_ADJUST: begin
                sum <= '0;
                maxj <= '0;
                state <= S_SUM;
              end
              default: begin
                result <= '{32'sd0, item.current_size, status_reg};
                state <= S_OUT;
              end
            endcase
          end
        end
        S_REC: begin
          if (base_valid)
            ring_pointer <= (ring_pointer == RingAw'(RingDepth - 1)) ? '0 : ring_pointer + 1'b1;
          result <= '{base_valid ? jit : 32'sd0, it.current_size, status_reg};
          state <= S_OUT;
        end
        S_SUM: begin
          // read issued at cnt, data arrives in the next cycle
          cnt <= cnt + 1'b1;
          if (cnt != '0) begin
            sum <= sum + rd_sat;
            if (rd_s > maxj) maxj <= rd_s;
          end
          if (cnt == (RingAw+1)'(RingDepth)) state <= S_MEAN;
        end
        S_MEAN: begin
          mean_q8 <= 40'(sum) <<< (8 - RingAw);
          sq <= '0;
          cnt <= '0;
          state <= S_VAR;
        end
        S_VAR: begin
          cnt <= cnt + 1'b1;
          if (cnt != '0) sq <= sq + 64'(dabs[31:0]) * 64'(dabs[31:0]);
          if (cnt == (RingAw+1)'(RingDepth)) begin
            state <= S_SQRT;
            root <= '0;
            bit_i <= 6'd31;
          end
        end
        S_SQRT: begin
          if (trial_sq <= var_q16) root <= trial;
          bit_i <= bit_i - 1'b1;
          if (bit_i == 6'd0) state <= S_MUL;
        end
        S_MUL: begin
          est <= {mean_q8[39], mean_q8} + zprod;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          wgt <= 41'(wprod[63:34]) + 41'd1;
          result.jitter_ms <= 32'sd0;
          if (est >= cap_q8) begin
            result.next_size <= it.current_size;
            result.net_status <= ST_BAD;
            state <= S_GROW;
          end else begin
            state <= S_OUT;
            if (est < thr_q8 && maxj < thr) begin
              if (status_reg != ST_GOOD) begin
                good_since_ms <= it.now_ms;
                status_reg <= ST_GOOD;
                result.next_size <= it.current_size;
                result.net_status <= ST_GOOD;
              end else if ((it.now_ms - good_since_ms) >= reduce_hold_ms) begin
                if (it.current_size > min_size)
                  result.next_size <= (it.current_size > 10'(step_size)) ?
                    it.current_size - 10'(step_size) : 10'd0;
                else
                  result.next_size <= it.current_size;
                status_reg <= ST_NORMAL;
                result.net_status <= ST_NORMAL;
              end else begin
                result.next_size <= it.current_size;
                result.net_status <= ST_GOOD;
              end
            end else begin
              status_reg <= ST_NORMAL;
              result.next_size <= it.current_size;
              result.net_status <= ST_NORMAL;
            end
          end
        end
        S_GROW: begin
          status_reg <= ST_BAD;
          state <= S_OUT;
          if (!grow_valid || (it.now_ms - last_grow_ms) >= 32'(GrowGapMs)) begin
            last_grow_ms <= it.now_ms;
            grow_valid <= 1'b1;
            if (improved_mode) begin
              if (it.current_size < max_size)
                result.next_size <= (11'(it.current_size) + 11'(step_size) > 11'(max_size))
                  ? max_size : it.current_size + 10'(step_size);
            end else begin
              if ((41'(it.current_size) + (wgt >= 41'd3 ? wgt + ((wgt + 41'd1) >> 1) : wgt))
                  >= 41'(max_size))
                result.next_size <= max_size;
              else
                result.next_size <= it.current_size + 10'(wgt >= 41'd3 ?
                  wgt + ((wgt + 41'd1) >> 1) : wgt);
            end
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign var_q16 = sq >> RingAw;
  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("done outside idle");
  a_status_valid: assert property (@(posedge clk) disable iff (rst)
    status_reg != ST_RSVD) else $error("bad status");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
`endif
endmodule
